[rtl/core/odei_pkg.sv]
// Package: shared constants and types for the ODE Euler/Heun integrator.
`timescale 1ns / 1ps
package odei_pkg;
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int CNT_W     = 6;
    localparam int IDX_W     = 3;

    localparam logic [CNT_W-1:0] MAX_STEPS = 6'd63;

    localparam logic [IDX_W-1:0] REG_METHOD = 3'd0;
    localparam logic [IDX_W-1:0] REG_FORM   = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEFFA = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEFFB = 3'd3;
    localparam logic [IDX_W-1:0] REG_STEP   = 3'd4;
    localparam logic [IDX_W-1:0] REG_COUNT  = 3'd5;

    localparam logic [1:0] FORM_ADD = 2'd0;
    localparam logic [1:0] FORM_SUB = 2'd1;
    localparam logic [1:0] FORM_MUL = 2'd2;
    localparam logic [1:0] FORM_DIV = 2'd3;

    localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] S_MIN = 32'sh80000000;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2,
        OP_AVG = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic               sat;
        logic [DATA_W-1:0]  res;
    } alu_res_t;
endpackage

[rtl/core/odei_div.sv]
// Iterative signed fixed-point divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module odei_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [odei_pkg::DATA_W-1:0] num,
    input  logic signed [odei_pkg::DATA_W-1:0] den,
    output logic                           done,
    output logic [odei_pkg::DATA_W-1:0]    quo,
    output logic                           sat
);
    import odei_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]   q_reg, q_next;
    logic [DATA_W:0] r_reg, r_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic            neg_reg, neg_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [DATA_W:0] trial;
    logic [NW:0]     mag;

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg; neg_next = neg_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        trial = {r_reg[DATA_W-1:0], q_reg[NW-1]} - {1'b0, d_reg};
        if (start) begin
            q_next   = {(num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num)), {FRAC_BITS{1'b0}}};
            d_next   = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
            r_next   = '0;
            neg_next = num[DATA_W-1] ^ den[DATA_W-1];
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DATA_W]) begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = {r_reg[DATA_W-1:0], q_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next; neg_reg <= neg_next;
    end

    always_comb begin
        mag = neg_reg ? (NW+1)'(-{1'b0, q_reg}) : {1'b0, q_reg};
        sat = 1'b0;
        quo = mag[DATA_W-1:0];
        if (!neg_reg && q_reg > NW'(S_MAX)) begin
            sat = 1'b1; quo = S_MAX;
        end else if (neg_reg && q_reg > NW'(33'h080000000)) begin
            sat = 1'b1; quo = S_MIN;
        end
    end
    assign done = done_reg;

    property p_done_pulse;
        @(posedge aclk) disable iff (!aresetn) done_reg |=> !done_reg;
    endproperty
    a_done_pulse: assert property (p_done_pulse) else $error("divider done held");
    property p_start_busy;
        @(posedge aclk) disable iff (!aresetn) start |=> busy_reg;
    endproperty
    a_start_busy: assert property (p_start_busy) else $error("divider not busy");
    property p_done_idle;
        @(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg;
    endproperty
    a_done_idle: assert property (p_done_idle) else $error("divider busy at done");
endmodule

[rtl/core/odei_alu.sv]
// Shared saturating fixed-point arithmetic unit.
`timescale 1ns / 1ps
module odei_alu (
    input  odei_pkg::alu_op_t                  op,
    input  logic signed [odei_pkg::DATA_W-1:0] opa,
    input  logic signed [odei_pkg::DATA_W-1:0] opb,
    output odei_pkg::alu_res_t                 res
);
    import odei_pkg::*;

    logic signed [2*DATA_W-1:0] prod;
    logic signed [2*DATA_W-1:0] prod_sh;
    logic signed [DATA_W:0]     sum;

    always_comb begin
        prod    = opa * opb;
        prod_sh = prod >>> FRAC_BITS;
        sum     = '0;
        res     = '0;
        case (op)
            OP_MUL: begin
                if (prod_sh > 64'(S_MAX)) begin
                    res.sat = 1'b1; res.res = S_MAX;
                end else if (prod_sh < 64'(S_MIN)) begin
                    res.sat = 1'b1; res.res = S_MIN;
                end else begin
                    res.res = prod_sh[DATA_W-1:0];
                end
            end
            OP_ADD, OP_SUB: begin
                sum = (op == OP_ADD) ? ({opa[DATA_W-1], opa} + {opb[DATA_W-1], opb})
                                     : ({opa[DATA_W-1], opa} - {opb[DATA_W-1], opb});
                if (sum[DATA_W] != sum[DATA_W-1]) begin
                    res.sat = 1'b1;
                    res.res = sum[DATA_W] ? S_MIN : S_MAX;
                end else begin
                    res.res = sum[DATA_W-1:0];
                end
            end
            OP_AVG: begin
                sum = {opa[DATA_W-1], opa} + {opb[DATA_W-1], opb};
                res.res = sum[DATA_W:1];
            end
            default: res = '0;
        endcase
    end
endmodule

[rtl/core/ode_euler_heun_integrator.sv]
// Top level: ODE integrator, Euler or Heun, Q16.16, one shared ALU under a sequencer.
//
// Channel  | Dir | Handshake            | Payload
// s_       | in  | s_valid / s_ready    | s_start_x, s_start_y
// m_       | out | m_valid / m_ready    | m_point_index, m_x_value, m_y_value,
//          |     |                      | m_last_point, m_saturated
// cfg_     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One ALU operation per cycle, except while the sequencer waits for the divider or for
// the output register to be taken; a Heun step evaluates the slope twice, and the divide
// form waits on the bit-serial divider for each slope with a nonzero denominator.
// A run is step_count+1 results; each waits in the output register until taken.
// The input is not ready from acceptance until the last point is taken.
// Reset is synchronous, active low, and restores the register defaults.
`timescale 1ns / 1ps
module ode_euler_heun_integrator (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [odei_pkg::DATA_W-1:0]     s_start_x,
    input  logic signed [odei_pkg::DATA_W-1:0]     s_start_y,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [odei_pkg::CNT_W-1:0]             m_point_index,
    output logic signed [odei_pkg::DATA_W-1:0]     m_x_value,
    output logic signed [odei_pkg::DATA_W-1:0]     m_y_value,
    output logic                                   m_last_point,
    output logic                                   m_saturated,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [odei_pkg::IDX_W-1:0]             cfg_index,
    input  logic [odei_pkg::DATA_W-1:0]            cfg_data
);
    import odei_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_EMIT, ST_AX, ST_BY, ST_COMB, ST_MUL2, ST_DIVW,
        ST_SDONE, ST_HS, ST_YP, ST_XH, ST_AVG, ST_HA, ST_YN, ST_XN
    } state_t;

    state_t state_reg;
    logic              meth_reg;
    logic [1:0]        form_reg;
    logic [DATA_W-1:0] ca_reg, cb_reg, h_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [DATA_W-1:0] x_reg, y_reg, ex_reg, ey_reg, t1_reg, t2_reg, s1_reg, sl_reg;
    logic [CNT_W-1:0]  n_reg, i_reg;
    logic              ph2_reg, ov_reg;
    logic              mv_reg;
    logic [CNT_W-1:0]  mi_reg;
    logic [DATA_W-1:0] mx_reg, my_reg;
    logic              ml_reg, ms_reg;

    alu_op_t           op;
    logic [DATA_W-1:0] opa, opb;
    alu_res_t          ar;
    logic              div_start, div_done, div_sat;
    logic [DATA_W-1:0] div_q;

    odei_alu u_alu (.op(op), .opa(opa), .opb(opb), .res(ar));
    odei_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(t1_reg), .den(t2_reg), .done(div_done), .quo(div_q), .sat(div_sat)
    );

    assign s_ready   = (state_reg == ST_IDLE) && !mv_reg;
    assign cfg_ready = 1'b1;
    assign m_valid = mv_reg;
    assign m_point_index = mi_reg;
    assign m_x_value = mx_reg;
    assign m_y_value = my_reg;
    assign m_last_point = ml_reg;
    assign m_saturated = ms_reg;

    always_comb begin
        op = OP_MUL; opa = ca_reg; opb = ex_reg; div_start = 1'b0;
        case (state_reg)
            ST_AX:   begin op = OP_MUL; opa = ca_reg; opb = ex_reg; end
            ST_BY:   begin op = OP_MUL; opa = cb_reg; opb = ey_reg; end
            ST_COMB: begin
                op  = (form_reg == FORM_SUB) ? OP_SUB : (form_reg == FORM_ADD) ? OP_ADD : OP_MUL;
                opa = t1_reg; opb = (form_reg == FORM_MUL) ? cb_reg : t2_reg;
                div_start = (form_reg == FORM_DIV) && (t2_reg != '0);
            end
            ST_MUL2: begin op = OP_MUL; opa = t1_reg; opb = ey_reg; end
            ST_HS:   begin op = OP_MUL; opa = h_reg; opb = sl_reg; end
            ST_YP:   begin op = OP_ADD; opa = y_reg; opb = t1_reg; end
            ST_XH:   begin op = OP_ADD; opa = x_reg; opb = h_reg; end
            ST_AVG:  begin op = OP_AVG; opa = s1_reg; opb = sl_reg; end
            ST_HA:   begin op = OP_MUL; opa = h_reg; opb = sl_reg; end
            ST_YN:   begin op = OP_ADD; opa = y_reg; opb = t1_reg; end
            ST_XN:   begin op = OP_ADD; opa = x_reg; opb = h_reg; end
            default: begin op = OP_MUL; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            meth_reg <= 1'b0; form_reg <= FORM_ADD;
            ca_reg <= 32'd65536; cb_reg <= 32'd65536; h_reg <= 32'd6554;
            cnt_reg <= 6'd10;
            mv_reg <= 1'b0; ov_reg <= 1'b0; ph2_reg <= 1'b0;
            n_reg <= '0; i_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_METHOD: meth_reg <= cfg_data[0];
                    REG_FORM:   form_reg <= cfg_data[1:0];
                    REG_COEFFA: ca_reg <= cfg_data;
                    REG_COEFFB: cb_reg <= cfg_data;
                    REG_STEP:   h_reg <= cfg_data;
                    REG_COUNT:  cnt_reg <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (mv_reg && m_ready && (state_reg != ST_EMIT)) mv_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    x_reg <= s_start_x; y_reg <= s_start_y;
                    n_reg <= (cnt_reg > MAX_STEPS) ? MAX_STEPS : cnt_reg;
                    i_reg <= '0; ov_reg <= 1'b0;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: if (!mv_reg || m_ready) begin
                    mv_reg <= 1'b1; mi_reg <= i_reg; mx_reg <= x_reg; my_reg <= y_reg;
                    ml_reg <= (i_reg == n_reg); ms_reg <= ov_reg;
                    if (i_reg == n_reg) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                        ex_reg <= x_reg; ey_reg <= y_reg; ph2_reg <= 1'b0;
                        state_reg <= ST_AX;
                    end
                end
                ST_AX: begin t1_reg <= ar.res; ov_reg <= ov_reg | ar.sat;
                    state_reg <= (form_reg == FORM_MUL) ? ST_COMB : ST_BY; end
                ST_BY: begin t2_reg <= ar.res; ov_reg <= ov_reg | ar.sat; state_reg <= ST_COMB; end
                ST_COMB: begin
                    if (form_reg == FORM_DIV) begin
                        if (t2_reg == '0) begin
                            sl_reg <= '0; state_reg <= ST_SDONE;
                        end else state_reg <= ST_DIVW;
                    end else if (form_reg == FORM_MUL) begin
                        t1_reg <= ar.res; ov_reg <= ov_reg | ar.sat; state_reg <= ST_MUL2;
                    end else begin
                        sl_reg <= ar.res; ov_reg <= ov_reg | ar.sat; state_reg <= ST_SDONE;
                    end
                end
                ST_MUL2: begin sl_reg <= ar.res; ov_reg <= ov_reg | ar.sat; state_reg <= ST_SDONE; end
                ST_DIVW: if (div_done) begin
                    sl_reg <= div_q; ov_reg <= ov_reg | div_sat; state_reg <= ST_SDONE;
                end
                ST_SDONE: begin
                    if (meth_reg && ph2_reg) state_reg <= ST_AVG;
                    else begin
                        if (meth_reg) s1_reg <= sl_reg;
                        state_reg <= ST_HS;
                    end
                end
                ST_HS: begin t1_reg <= ar.res; ov_reg <= ov_reg | ar.sat;
                    state_reg <= meth_reg ? ST_YP : ST_YN; end
                ST_YP: begin ey_reg <= ar.res; ov_reg <= ov_reg | ar.sat; state_reg <= ST_XH; end
                ST_XH: begin ex_reg <= ar.res; ov_reg <= ov_reg | ar.sat;
                    ph2_reg <= 1'b1; state_reg <= ST_AX; end
                ST_AVG: begin sl_reg <= ar.res; state_reg <= ST_HA; end
                ST_HA: begin t1_reg <= ar.res; ov_reg <= ov_reg | ar.sat; state_reg <= ST_YN; end
                ST_YN: begin y_reg <= ar.res; ov_reg <= ov_reg | ar.sat; state_reg <= ST_XN; end
                ST_XN: begin x_reg <= ar.res; ov_reg <= ov_reg | ar.sat; state_reg <= ST_EMIT; end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    property p_hold;
        @(posedge aclk) disable iff (!aresetn) mv_reg && !m_ready |=> mv_reg && $stable(mi_reg);
    endproperty
    a_hold: assert property (p_hold) else $error("result dropped");
    property p_busy;
        @(posedge aclk) disable iff (!aresetn) (state_reg != ST_IDLE) |-> !s_ready;
    endproperty
    a_busy: assert property (p_busy) else $error("ready while busy");
    property p_idx;
        @(posedge aclk) disable iff (!aresetn) mv_reg |-> (mi_reg <= n_reg);
    endproperty
    a_idx: assert property (p_idx) else $error("index beyond run");
endmodule

[tb/tb_ode_euler_heun_integrator.sv]
// Testbench for the Euler/Heun ODE integrator: directed table plus random runs against a predictor.
`timescale 1ns / 1ps
module tb_ode_euler_heun_integrator;
    import odei_pkg::*;

    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [CNT_W-1:0]         idx;
        logic signed [DATA_W-1:0] xv;
        logic signed [DATA_W-1:0] yv;
        logic                     last;
        logic                     sat;
    } point_t;

    typedef struct {
        logic                     is_cfg;
        logic [IDX_W-1:0]         reg_idx;
        logic [DATA_W-1:0]        value;
        logic signed [DATA_W-1:0] sx;
        logic signed [DATA_W-1:0] sy;
        logic                     known;
        logic signed [DATA_W-1:0] end_y;
    } row_t;

    logic aclk;
    logic aresetn;
    logic s_valid, s_ready;
    logic signed [DATA_W-1:0] s_start_x, s_start_y;
    logic m_valid, m_ready;
    logic [CNT_W-1:0] m_point_index;
    logic signed [DATA_W-1:0] m_x_value, m_y_value;
    logic m_last_point, m_saturated;
    logic cfg_valid, cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    logic       mdl_method;
    logic [1:0] mdl_form;
    longint     mdl_a, mdl_b, mdl_h;
    int         mdl_count;
    bit         mdl_ovf;

    point_t points_due[$];
    logic signed [DATA_W-1:0] end_y_due[$];
    int     mismatches;
    int     idle_cycles;
    bit     stim_done;

    ode_euler_heun_integrator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_x(s_start_x), .s_start_y(s_start_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_point_index(m_point_index), .m_x_value(m_x_value), .m_y_value(m_y_value),
        .m_last_point(m_last_point), .m_saturated(m_saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint sat_q(longint v);
        if (v > 64'sd2147483647) begin
            mdl_ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            mdl_ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint q_mul(longint p, longint q);
        return sat_q((p * q) >>> FRAC_BITS);
    endfunction

    function automatic longint q_div(longint n, longint d);
        if (d == 0) return 0;
        return sat_q((n * 65536) / d);
    endfunction

    function automatic longint slope_at(longint x, longint y);
        longint ax;
        ax = q_mul(mdl_a, x);
        case (mdl_form)
            FORM_ADD: return sat_q(ax + q_mul(mdl_b, y));
            FORM_SUB: return sat_q(ax - q_mul(mdl_b, y));
            FORM_MUL: return q_mul(q_mul(ax, mdl_b), y);
            default:  return q_div(ax, q_mul(mdl_b, y));
        endcase
    endfunction

    function automatic void apply_reg(logic [IDX_W-1:0] r, logic [DATA_W-1:0] v);
        case (r)
            REG_METHOD: mdl_method = v[0];
            REG_FORM:   mdl_form = v[1:0];
            REG_COEFFA: mdl_a = longint'(signed'(v));
            REG_COEFFB: mdl_b = longint'(signed'(v));
            REG_STEP:   mdl_h = longint'(signed'(v));
            REG_COUNT:  mdl_count = int'(v[5:0]);
            default: ;
        endcase
    endfunction

    function automatic void predict_run(logic signed [DATA_W-1:0] sx,
                                        logic signed [DATA_W-1:0] sy);
        longint x, y, s1, s2, yp;
        int n;
        point_t p;
        n = (mdl_count > 63) ? 63 : mdl_count;
        x = sx;
        y = sy;
        mdl_ovf = 1'b0;
        for (int i = 0; i <= n; i++) begin
            if (i > 0) begin
                if (mdl_method) begin
                    s1 = slope_at(x, y);
                    yp = sat_q(y + q_mul(mdl_h, s1));
                    s2 = slope_at(sat_q(x + mdl_h), yp);
                    y = sat_q(y + q_mul(mdl_h, (s1 + s2) >>> 1));
                end else begin
                    y = sat_q(y + q_mul(mdl_h, slope_at(x, y)));
                end
                x = sat_q(x + mdl_h);
            end
            p.idx = i[CNT_W-1:0];
            p.xv = x[31:0];
            p.yv = y[31:0];
            p.last = (i == n);
            p.sat = mdl_ovf;
            points_due = {points_due, p};
        end
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] r, logic [DATA_W-1:0] v);
        repeat ($urandom_range(0, 14)) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = r;
        cfg_data  = v;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(r, v);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_start(logic signed [DATA_W-1:0] sx, logic signed [DATA_W-1:0] sy);
        repeat ($urandom_range(0, 14)) @(negedge aclk);
        s_valid   = 1'b1;
        s_start_x = sx;
        s_start_y = sy;
        do @(posedge aclk); while (!s_ready);
        predict_run(sx, sy);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain();
        while (points_due.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic random_config(bit big_count);
        logic [DATA_W-1:0] v;
        write_reg(REG_METHOD, $urandom_range(0, 1));
        write_reg(REG_FORM, $urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: v = $urandom;
            default: v = $urandom_range(0, 262144) - 131072;
        endcase
        write_reg(REG_COEFFA, v);
        case ($urandom_range(0, 3))
            0: v = $urandom;
            default: v = $urandom_range(0, 262144) - 131072;
        endcase
        write_reg(REG_COEFFB, v);
        v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32768) - 16384;
        write_reg(REG_STEP, v);
        write_reg(REG_COUNT, big_count ? $urandom_range(40, 63) : $urandom_range(0, 8));
    endtask

    // receive side
    initial begin
        point_t e;
        int gap;
        m_ready = 1'b0;
        gap = 0;
        forever begin
            @(negedge aclk);
            if (gap > 0) begin
                gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (points_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected point idx=%0d x=%h y=%h",
                                 m_point_index, m_x_value, m_y_value);
                end else begin
                    e = points_due.pop_front();
                    if (e.idx !== m_point_index || e.xv !== m_x_value ||
                        e.yv !== m_y_value || e.last !== m_last_point ||
                        e.sat !== m_saturated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %0d %h %h %b %b got %0d %h %h %b %b",
                                     e.idx, e.xv, e.yv, e.last, e.sat, m_point_index,
                                     m_x_value, m_y_value, m_last_point, m_saturated);
                    end
                    if (e.last && end_y_due.size() != 0) begin
                        if (end_y_due.pop_front() !== m_y_value) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("final y mismatch got %h", m_y_value);
                        end
                    end
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready) || (stim_done && points_due.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        row_t tbl[$];
        row_t r;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_start_x = '0;
        s_start_y = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        stim_done = 0;
        mdl_method = 1'b0;
        mdl_form = FORM_ADD;
        mdl_a = 65536;
        mdl_b = 65536;
        mdl_h = 6554;
        mdl_count = 10;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table: config rows and start rows; known end y where obvious
        tbl = '{
            '{0, 0, 0, 32'sd0, 32'sd0, 0, 0},
            '{0, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0},
            '{0, 0, 0, 32'sh80000000, 32'sh80000000, 0, 0},
            '{1, REG_COUNT, 0, 0, 0, 0, 0},
            '{0, 0, 0, 32'sh00010000, 32'sh12345678, 1, 32'sh12345678},
            '{1, REG_COUNT, 63, 0, 0, 0, 0},
            '{0, 0, 0, 32'sh00010000, 32'sh00010000, 0, 0},
            '{1, REG_COUNT, 3, 0, 0, 0, 0},
            '{1, REG_FORM, FORM_SUB, 0, 0, 0, 0},
            '{0, 0, 0, 32'sh00020000, -32'sh00010000, 0, 0},
            '{1, REG_FORM, FORM_MUL, 0, 0, 0, 0},
            '{0, 0, 0, 32'sh40000000, 32'sh40000000, 0, 0},
            '{1, REG_FORM, FORM_DIV, 0, 0, 0, 0},
            '{0, 0, 0, 32'sh00010000, 32'sd0, 1, 32'sd0},
            '{0, 0, 0, 32'sh00030000, 32'sh00020000, 0, 0},
            '{1, REG_METHOD, 1, 0, 0, 0, 0},
            '{0, 0, 0, 32'sh00030000, 32'sh00020000, 0, 0},
            '{1, REG_FORM, FORM_ADD, 0, 0, 0, 0},
            '{1, REG_COEFFA, 32'h7FFFFFFF, 0, 0, 0, 0},
            '{1, REG_COEFFB, 32'h80000000, 0, 0, 0, 0},
            '{1, REG_STEP, 32'h7FFFFFFF, 0, 0, 0, 0},
            '{0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0},
            '{1, REG_STEP, 32'h80000000, 0, 0, 0, 0},
            '{1, 3'd7, 32'hFFFFFFFF, 0, 0, 0, 0},
            '{0, 0, 0, 32'sh80000000, 32'sh7FFFFFFF, 0, 0}
        };
        foreach (tbl[i]) begin
            r = tbl[i];
            if (r.is_cfg) begin
                drain();
                write_reg(r.reg_idx, r.value);
            end else begin
                if (r.known) end_y_due = {end_y_due, r.end_y};
                send_start(r.sx, r.sy);
            end
        end

        for (int k = 0; k < 108; k++) begin
            if (k % 10 == 0) begin
                drain();
                random_config(k % 40 == 30);
            end
            case ($urandom_range(0, 3))
                0: send_start($urandom, $urandom);
                default: send_start($urandom_range(0, 524288) - 262144,
                                    $urandom_range(0, 524288) - 262144);
            endcase
        end
        stim_done = 1;
        drain();
        if (mismatches == 0 && points_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
